[rtl/mbr_pkg.sv]
// Shared constants, types and state codes for the median baseline removal block.
// No dependencies; every other file in rtl/ refers to it by scoped names.
package mbr_pkg;

  localparam int SMP_W      = 16;
  localparam int RES_W      = SMP_W + 1;
  localparam int WIN1       = 127;
  localparam int WIN2       = 255;
  localparam int DELAY      = 125;
  localparam int DLEN       = DELAY + 1;
  localparam int FULL_COUNT = WIN1 + WIN2 - 1;
  localparam int FILL_W     = $clog2(FULL_COUNT + 1);
  localparam int MID1       = (WIN1 - 1) / 2;
  localparam int MID2       = (WIN2 - 1) / 2;

  typedef logic signed [SMP_W-1:0] smp_t;
  typedef logic signed [RES_W-1:0] res_t;
  typedef logic [FILL_W-1:0]       fill_t;

  // Broadcast to every cell of one sorted chain.
  typedef struct packed {
    logic en;
    logic clr;
    smp_t x;
    smp_t old;
    logic old_lt_x;
  } upd_t;

  // What a cell shows its neighbors.
  typedef struct packed {
    smp_t val;
    logic lt;
    logic le;
  } cell_out_t;

  localparam cell_out_t EDGE_LEFT  = '{val: '0, lt: 1'b1, le: 1'b1};
  localparam cell_out_t EDGE_RIGHT = '{val: '0, lt: 1'b0, le: 1'b0};

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_TWO,
    ST_RES
  } st_t;

endpackage

[rtl/mbr_cell.sv]
// One cell of a sorted window chain: holds one sorted entry and updates it from
// its own compares and those of its two neighbors. Depends on mbr_pkg.
module mbr_cell (
  input  logic               clk,
  input  logic               rst,
  input  mbr_pkg::upd_t      upd,
  input  mbr_pkg::cell_out_t left_nb,
  input  mbr_pkg::cell_out_t right_nb,
  output mbr_pkg::cell_out_t cur
);

  mbr_pkg::smp_t val;
  mbr_pkg::smp_t val_next;
  logic          lt;
  logic          le;
  logic          below;
  logic          at;

  assign lt = val < upd.x;
  assign le = val <= upd.old;

  assign cur.val = val;
  assign cur.lt  = lt;
  assign cur.le  = le;

  // Oldest entry leaves at the last cell not above it; the new one goes before equals.
  always_comb begin
    if (upd.old_lt_x) begin
      below = right_nb.lt;
      at    = lt && !right_nb.lt;
    end else begin
      below = lt;
      at    = left_nb.lt && !lt;
    end
    if (below) begin
      val_next = right_nb.le ? val : right_nb.val;
    end else if (at) begin
      val_next = upd.x;
    end else begin
      val_next = le ? left_nb.val : val;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || upd.clr) begin
      val <= '0;
    end else if (upd.en) begin
      val <= val_next;
    end
  end

endmodule

[rtl/median_baseline_removal_top.sv]
// Top level: two sorted cell chains, window and delay shift lines, sequencer and
// output register. Depends on mbr_pkg and mbr_cell.
//
// For each transfer, the stage-one chain updates at the input transfer, the
// stage-two chain in the next cycle from the new stage-one median (only once WIN1
// samples have been counted), and the result is loaded into the output register
// once that register is free or being drained. Input ready is high only while the
// sequencer is idle, so a new transfer is taken only after the previous result has
// been loaded; a result waiting in the output register does not block the next
// input. A clear transfer zeroes all windows, the delay line and the count, and returns corrected = 0, ready_res = 0.
module median_baseline_removal_top (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  mbr_pkg::smp_t        sample,
  input  logic                 clear,
  output logic                 out_valid,
  input  logic                 out_ready,
  output mbr_pkg::res_t        corrected,
  output logic                 ready_res
);

  mbr_pkg::st_t       st;
  mbr_pkg::st_t       st_next;
  mbr_pkg::fill_t     fill;
  mbr_pkg::smp_t      win_one [mbr_pkg::WIN1];
  mbr_pkg::smp_t      win_two [mbr_pkg::WIN2];
  mbr_pkg::smp_t      dly     [mbr_pkg::DLEN];
  mbr_pkg::cell_out_t c1_out  [mbr_pkg::WIN1];
  mbr_pkg::cell_out_t c2_out  [mbr_pkg::WIN2];
  mbr_pkg::upd_t      upd1;
  mbr_pkg::upd_t      upd2;
  mbr_pkg::smp_t      med1;
  mbr_pkg::res_t      diff;
  logic               xfer_in;
  logic               en1;
  logic               clr;
  logic               en2;
  logic               load;
  logic               full;

  assign xfer_in = in_valid && in_ready;
  assign en1     = xfer_in && !clear;
  assign clr     = xfer_in && clear;
  assign full    = fill == mbr_pkg::fill_t'(mbr_pkg::FULL_COUNT);
  assign med1    = c1_out[mbr_pkg::MID1].val;

  assign upd1.en       = en1;
  assign upd1.clr      = clr;
  assign upd1.x        = sample;
  assign upd1.old      = win_one[0];
  assign upd1.old_lt_x = win_one[0] < sample;

  assign upd2.en       = en2;
  assign upd2.clr      = clr;
  assign upd2.x        = med1;
  assign upd2.old      = win_two[0];
  assign upd2.old_lt_x = win_two[0] < med1;

  // Stage-one sorted chain.
  for (genvar i = 0; i < mbr_pkg::WIN1; i++) begin : g_one
    mbr_pkg::cell_out_t lnb;
    mbr_pkg::cell_out_t rnb;
    if (i == 0) begin : g_l
      assign lnb = mbr_pkg::EDGE_LEFT;
    end else begin : g_l
      assign lnb = c1_out[i-1];
    end
    if (i == mbr_pkg::WIN1 - 1) begin : g_r
      assign rnb = mbr_pkg::EDGE_RIGHT;
    end else begin : g_r
      assign rnb = c1_out[i+1];
    end
    mbr_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .upd      (upd1),
      .left_nb  (lnb),
      .right_nb (rnb),
      .cur      (c1_out[i])
    );
  end

  // Stage-two sorted chain.
  for (genvar i = 0; i < mbr_pkg::WIN2; i++) begin : g_two
    mbr_pkg::cell_out_t lnb;
    mbr_pkg::cell_out_t rnb;
    if (i == 0) begin : g_l
      assign lnb = mbr_pkg::EDGE_LEFT;
    end else begin : g_l
      assign lnb = c2_out[i-1];
    end
    if (i == mbr_pkg::WIN2 - 1) begin : g_r
      assign rnb = mbr_pkg::EDGE_RIGHT;
    end else begin : g_r
      assign rnb = c2_out[i+1];
    end
    mbr_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .upd      (upd2),
      .left_nb  (lnb),
      .right_nb (rnb),
      .cur      (c2_out[i])
    );
  end

  // Window and delay shift lines, oldest at index 0.
  always_ff @(posedge clk) begin
    if (rst || clr) begin
      for (int i = 0; i < mbr_pkg::WIN1; i++) win_one[i] <= '0;
      for (int i = 0; i < mbr_pkg::DLEN; i++) dly[i] <= '0;
    end else if (en1) begin
      for (int i = 0; i < mbr_pkg::WIN1 - 1; i++) win_one[i] <= win_one[i+1];
      win_one[mbr_pkg::WIN1-1] <= sample;
      for (int i = 0; i < mbr_pkg::DLEN - 1; i++) dly[i] <= dly[i+1];
      dly[mbr_pkg::DLEN-1] <= sample;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || clr) begin
      for (int i = 0; i < mbr_pkg::WIN2; i++) win_two[i] <= '0;
    end else if (en2) begin
      for (int i = 0; i < mbr_pkg::WIN2 - 1; i++) win_two[i] <= win_two[i+1];
      win_two[mbr_pkg::WIN2-1] <= med1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || clr) begin
      fill <= '0;
    end else if (en1 && !full) begin
      fill <= fill + mbr_pkg::fill_t'(1);
    end
  end

  // Sequencer.
  always_comb begin
    case (st)
      mbr_pkg::ST_IDLE: st_next = xfer_in ? mbr_pkg::ST_TWO : mbr_pkg::ST_IDLE;
      mbr_pkg::ST_TWO:  st_next = mbr_pkg::ST_RES;
      mbr_pkg::ST_RES:  st_next = load ? mbr_pkg::ST_IDLE : mbr_pkg::ST_RES;
      default:          st_next = mbr_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready = 1'b0;
    en2      = 1'b0;
    load     = 1'b0;
    case (st)
      mbr_pkg::ST_IDLE: in_ready = 1'b1;
      mbr_pkg::ST_TWO:  en2 = fill >= mbr_pkg::fill_t'(mbr_pkg::WIN1);
      mbr_pkg::ST_RES:  load = !out_valid || out_ready;
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= mbr_pkg::ST_IDLE;
    end else begin
      st <= st_next;
    end
  end

  // Output register.
  assign diff = mbr_pkg::res_t'(dly[0]) - mbr_pkg::res_t'(c2_out[mbr_pkg::MID2].val);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      corrected <= full ? diff : '0;
      ready_res <= full;
    end
  end

  a_sorted_one: assert property (@(posedge clk) disable iff (rst)
    c1_out[0].val <= c1_out[mbr_pkg::MID1].val &&
    c1_out[mbr_pkg::MID1].val <= c1_out[mbr_pkg::WIN1-1].val)
    else $error("stage-one chain out of order");

  a_sorted_two: assert property (@(posedge clk) disable iff (rst)
    c2_out[0].val <= c2_out[mbr_pkg::MID2].val &&
    c2_out[mbr_pkg::MID2].val <= c2_out[mbr_pkg::WIN2-1].val)
    else $error("stage-two chain out of order");

  a_fill_cap: assert property (@(posedge clk) disable iff (rst)
    fill <= mbr_pkg::fill_t'(mbr_pkg::FULL_COUNT))
    else $error("fill count past full");

  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    xfer_in |=> !in_ready ##1 !in_ready)
    else $error("input taken while an item is in flight");

  a_two_follows: assert property (@(posedge clk) disable iff (rst)
    en2 |-> $past(en1))
    else $error("stage two updated without a sample transfer");

endmodule

[tb/mbr_checker.sv]
`timescale 1ns / 100ps
// Checker for median_baseline_removal_top: watches both channels, predicts each result
// from the accepted input transfers and compares in order. Depends on mbr_pkg only.
module mbr_checker (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  input  logic            in_ready,
  input  mbr_pkg::smp_t   sample,
  input  logic            clear,
  input  logic            out_valid,
  input  logic            out_ready,
  input  mbr_pkg::res_t   corrected,
  input  logic            ready_res,
  output int              errors,
  output int              owed,
  output int              checked,
  output int              warm_results
);

  typedef mbr_pkg::smp_t smp_q_t[$];

  typedef struct packed {
    mbr_pkg::res_t corrected;
    logic          ready_res;
  } baseline_res_t;

  smp_q_t win_one, srt_one, win_two, srt_two, delay_q;
  int fill;
  baseline_res_t owed_q[$];

  function automatic smp_q_t zeros(int n);
    smp_q_t q;
    q = {};
    for (int i = 0; i < n; i++) q.push_back('0);
    return q;
  endfunction

  // Drop the first copy of old (last entry if none), then insert v in order.
  function automatic smp_q_t sorted_swap(smp_q_t s, mbr_pkg::smp_t old, mbr_pkg::smp_t v);
    int pos;
    pos = s.size() - 1;
    for (int i = s.size() - 1; i >= 0; i--) if (s[i] == old) pos = i;
    s.delete(pos);
    pos = 0;
    while (pos < s.size() && s[pos] <= v) pos++;
    s.insert(pos, v);
    return s;
  endfunction

  task automatic reset_windows();
    win_one = zeros(mbr_pkg::WIN1);
    srt_one = zeros(mbr_pkg::WIN1);
    win_two = zeros(mbr_pkg::WIN2);
    srt_two = zeros(mbr_pkg::WIN2);
    delay_q = zeros(mbr_pkg::DLEN);
    fill = 0;
  endtask

  task automatic baseline_step(input mbr_pkg::smp_t x, input logic clr,
                               output baseline_res_t r);
    mbr_pkg::smp_t old, m1;
    int d, m2;
    r = '0;
    if (clr) begin
      reset_windows();
    end else begin
      if (fill < mbr_pkg::FULL_COUNT) fill++;
      delay_q.push_back(x);
      void'(delay_q.pop_front());
      old = win_one.pop_front();
      win_one.push_back(x);
      srt_one = sorted_swap(srt_one, old, x);
      if (fill >= mbr_pkg::WIN1) begin
        m1 = srt_one[mbr_pkg::MID1];
        old = win_two.pop_front();
        win_two.push_back(m1);
        srt_two = sorted_swap(srt_two, old, m1);
      end
      if (fill >= mbr_pkg::FULL_COUNT) begin
        d = delay_q[0];
        m2 = srt_two[mbr_pkg::MID2];
        r.corrected = mbr_pkg::res_t'(d - m2);
        r.ready_res = 1'b1;
      end
    end
  endtask

  always @(posedge clk) begin : watch
    baseline_res_t exp_r;
    if (rst) begin
      reset_windows();
      owed_q.delete();
      errors = 0;
      checked = 0;
      warm_results = 0;
    end else begin
      if (out_valid && out_ready) begin
        if (owed_q.size() == 0) begin
          errors++;
          $display("%0t: unexpected transfer, expected none, got corrected=%0d ready_res=%0b",
                   $time, corrected, ready_res);
        end else begin
          exp_r = owed_q.pop_front();
          checked++;
          if (exp_r.ready_res) warm_results++;
          if (corrected !== exp_r.corrected) begin
            errors++;
            $display("%0t: corrected expected %0d got %0d", $time, exp_r.corrected, corrected);
          end
          if (ready_res !== exp_r.ready_res) begin
            errors++;
            $display("%0t: ready_res expected %0b got %0b", $time, exp_r.ready_res, ready_res);
          end
        end
      end
      if (in_valid && in_ready) begin
        baseline_step(sample, clear, exp_r);
        owed_q.push_back(exp_r);
      end
    end
    owed = owed_q.size();
  end

endmodule

[tb/median_baseline_removal_top_tb.sv]
`timescale 1ns / 100ps
// Testbench top for median_baseline_removal_top: clock, reset, stimulus and handshake
// pacing, verdict. Depends on mbr_pkg, mbr_checker and the block itself.
module median_baseline_removal_top_tb;

  localparam int ITEMS = 1500;
  localparam int LIMIT = 400000;
  localparam int HOLD  = 400;

  logic          clk       = 1'b0;
  logic          rst       = 1'b1;
  logic          in_valid  = 1'b0;
  logic          clear     = 1'b0;
  logic          out_ready = 1'b0;
  logic          hold_req  = 1'b0;
  logic          hold_done = 1'b0;
  mbr_pkg::smp_t sample    = '0;
  logic          in_ready, out_valid, ready_res;
  mbr_pkg::res_t corrected;

  int send_idle   = 0;
  int stall_pct   = 0;
  int cycles      = 0;
  int clears_sent = 0;
  int errors, owed, checked, warm_results;

  always #1 clk = ~clk;

  median_baseline_removal_top uut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .sample    (sample),
    .clear     (clear),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .corrected (corrected),
    .ready_res (ready_res)
  );

  mbr_checker chk (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .sample       (sample),
    .clear        (clear),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .corrected    (corrected),
    .ready_res    (ready_res),
    .errors       (errors),
    .owed         (owed),
    .checked      (checked),
    .warm_results (warm_results)
  );

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= LIMIT) begin
      $display("median_baseline_removal_top: mismatch");
      $finish;
    end
  end

  // Hold off the output for a long stretch on request, else stall at random.
  always begin
    @(negedge clk);
    if (hold_req && !hold_done) begin
      out_ready <= 1'b0;
      for (int i = 0; i < HOLD; i++) @(negedge clk);
      hold_done = 1'b1;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  task automatic push_sample(input mbr_pkg::smp_t s, input logic c);
    while ($urandom_range(0, 99) < send_idle) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    sample   <= s;
    clear    <= c;
    if (c) clears_sent++;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
  endtask

  initial begin : stim
    int mode, seg_left, drift, base, v;
    mbr_pkg::smp_t s;
    mode = 0;
    seg_left = 0;
    drift = 0;
    base = 0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    push_sample('0, 1'b1);
    push_sample(mbr_pkg::smp_t'(32767), 1'b0);
    push_sample(mbr_pkg::smp_t'(-32768), 1'b0);
    push_sample('0, 1'b0);
    push_sample(mbr_pkg::smp_t'(-1), 1'b0);
    push_sample(mbr_pkg::smp_t'(1), 1'b0);
    push_sample(mbr_pkg::smp_t'(21845), 1'b0);
    push_sample(mbr_pkg::smp_t'(-21846), 1'b0);
    push_sample(mbr_pkg::smp_t'(32767), 1'b0);
    push_sample(mbr_pkg::smp_t'(32767), 1'b0);
    push_sample(mbr_pkg::smp_t'(-32768), 1'b1);
    push_sample(mbr_pkg::smp_t'(32767), 1'b1);
    push_sample(mbr_pkg::smp_t'(16384), 1'b0);
    push_sample(mbr_pkg::smp_t'(-16384), 1'b0);
    push_sample(mbr_pkg::smp_t'(255), 1'b0);
    push_sample(mbr_pkg::smp_t'(-256), 1'b0);
    push_sample('0, 1'b1);

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin send_idle = 0;  stall_pct = 0;  end
        1: begin send_idle = 75; stall_pct = 0;  end
        2: begin send_idle = 0;  stall_pct = 75; end
        default: begin send_idle = 31; stall_pct = 31; end
      endcase
      for (int n = 0; n < ITEMS / 4; n++) begin
        if (ph == 0 && n == 150) hold_req = 1'b1;
        if (seg_left == 0) begin
          mode = $urandom_range(0, 3);
          seg_left = $urandom_range(40, 400);
          base = $urandom_range(0, 1) ? 32767 : -32768;
        end
        seg_left--;
        case (mode)
          0: s = mbr_pkg::smp_t'($urandom);
          1: s = mbr_pkg::smp_t'(int'($urandom_range(0, 6)) - 3);
          2: begin
            drift = drift + int'($urandom_range(0, 40)) - 20;
            if (drift > 20000) drift = 20000;
            if (drift < -20000) drift = -20000;
            v = drift + int'($urandom_range(0, 400)) - 200;
            if ($urandom_range(0, 39) == 0) v = v + 9000;
            s = mbr_pkg::smp_t'(v);
          end
          default: begin
            s = ($urandom_range(0, 7) == 0) ? mbr_pkg::smp_t'(-base - 1)
                                            : mbr_pkg::smp_t'(base);
          end
        endcase
        push_sample(s, $urandom_range(0, 599) == 0);
      end
    end

    in_valid <= 1'b0;
    stall_pct = 0;
    while (owed != 0) @(negedge clk);
    repeat (20) @(negedge clk);

    $display("%0d results checked, %0d of them past warm-up; %0d clear transfers",
             checked, warm_results, clears_sent);
    $display("stall phases: none, sender 75%%, receiver 75%%, both 31%%, one long output hold");
    if (errors == 0) begin
      $display("median_baseline_removal_top: match");
    end else begin
      $display("median_baseline_removal_top: mismatch");
    end
    $finish;
  end

endmodule
